// File: hw/rtl/frame_fenced_page_bump_allocator_assert.svh
// Assertion macros used by the allocator checker.
`ifndef FRAME_FENCED_PAGE_BUMP_ALLOCATOR_ASSERT_SVH
`define FRAME_FENCED_PAGE_BUMP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFPBA_ASSERT_NOW(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |-> (CONS)) \
    else $error("allocator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FFPBA_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |=> (CONS)) \
    else $error("allocator assertion failed");

`endif

// File: hw/rtl/ffpba_pkg.sv
`timescale 1ns / 1ps

package ffpba_pkg;

  // Fixed field widths.
  localparam int unsigned REQ_W     = 25;
  localparam int unsigned ALOG_W    = 4;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned PAGE_ID_W = 4;
  localparam int unsigned OFFS_W    = 24;
  localparam int unsigned GRANT_W   = 25;
  localparam int unsigned RECYC_W   = 5;
  localparam int unsigned PBYTES_W  = 25;
  localparam int unsigned SUM_W     = 26;

  localparam logic [PBYTES_W-1:0] PAGE_BYTES_RST = 25'd65536;

  // Item kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_PAGE   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RECYCLED  = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_FIT,
    S_POP,
    S_EVT_RD,
    S_EVT_WR,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/ffpba_if.sv
`timescale 1ns / 1ps

// Request channel: allocate requests and frame-completed events.
interface ffpba_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [ffpba_pkg::REQ_W-1:0]    request_bytes;
  logic [ffpba_pkg::ALOG_W-1:0]   alignment_log2;
  logic [ffpba_pkg::SLOT_W-1:0]   frame_slot;

  modport source (output valid, kind, request_bytes, alignment_log2, frame_slot,
                  input ready);
  modport sink (input valid, kind, request_bytes, alignment_log2, frame_slot,
                output ready);
endinterface

// Result channel.
interface ffpba_out_if;
  logic                             valid;
  logic                             ready;
  logic [ffpba_pkg::STAT_W-1:0]     status;
  logic [ffpba_pkg::PAGE_ID_W-1:0]  page_id;
  logic [ffpba_pkg::OFFS_W-1:0]     byte_offset;
  logic [ffpba_pkg::GRANT_W-1:0]    granted_bytes;
  logic [ffpba_pkg::RECYC_W-1:0]    recycled_count;

  modport source (output valid, status, page_id, byte_offset, granted_bytes,
                  recycled_count, input ready);
  modport sink (input valid, status, page_id, byte_offset, granted_bytes,
                recycled_count, output ready);
endinterface

// File: hw/rtl/frame_fenced_page_bump_allocator.sv
`timescale 1ns / 1ps

// Linear bump allocator over fixed-size pages with frame-fenced recycling.
// Items are handled one at a time by a small sequencer around a single
// shared 26-bit adder and comparator. An allocation passes the align, fit
// check and finish states (oversize ones skip the fit check); one reopening
// a page from the recycle FIFO also passes a pop state, as the FIFO memory
// has a registered read. A frame-completed event passes a read and a write
// state per pending page, each page going through the pending memory's read
// port and then the FIFO's write port. The output register lets the next
// item be taken while a result still waits. The user must set page size
// through cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module frame_fenced_page_bump_allocator #(
  parameter int MAX_PAGES   = 16,
  parameter int FRAME_SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ffpba_in_if.sink                         in_ch,
  ffpba_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [ffpba_pkg::PBYTES_W-1:0]   cfg_wdata
);

  localparam int PW     = $clog2(MAX_PAGES);
  localparam int CW     = $clog2(MAX_PAGES + 1);
  localparam int SW     = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int PDEPTH = FRAME_SLOTS * MAX_PAGES;
  localparam int PAW    = $clog2(PDEPTH);

  localparam int SUM_W = ffpba_pkg::SUM_W;
  localparam int PB_W  = ffpba_pkg::PBYTES_W;

  // Sequencer and configuration.
  ffpba_pkg::state_t state_r, state_nxt;
  logic [PB_W-1:0]   page_bytes_r;

  // Latched item.
  logic                        kind_r, kind_nxt;
  logic [ffpba_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [ffpba_pkg::ALOG_W-1:0] alog_r, alog_nxt;
  logic [SW-1:0]               slot_r, slot_nxt;

  // Allocator state.
  logic            page_open_r, page_open_nxt;
  logic [PW-1:0]   open_page_r, open_page_nxt;
  logic [PB_W-1:0] fill_off_r, fill_off_nxt;
  logic [CW-1:0]   pages_made_r, pages_made_nxt;
  logic [PW-1:0]   free_head_r, free_head_nxt;
  logic [PW-1:0]   free_tail_r, free_tail_nxt;
  logic [CW-1:0]   free_count_r, free_count_nxt;
  logic [CW-1:0]   pend_cnt_r [FRAME_SLOTS];
  logic [CW-1:0]   pend_cnt_nxt [FRAME_SLOTS];

  // Work registers.
  logic [ffpba_pkg::GRANT_W-1:0] gran_r, gran_nxt;
  logic [PB_W-1:0]               res_off_r, res_off_nxt;
  logic [ffpba_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [CW-1:0]                 evt_n_r, evt_n_nxt;
  logic [PW-1:0]                 idx_r, idx_nxt;

  // Output register.
  logic                             out_valid_r, out_valid_nxt;
  logic [ffpba_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [ffpba_pkg::PAGE_ID_W-1:0]  out_page_r, out_page_nxt;
  logic [ffpba_pkg::OFFS_W-1:0]     out_off_r, out_off_nxt;
  logic [ffpba_pkg::GRANT_W-1:0]    out_gran_r, out_gran_nxt;
  logic [ffpba_pkg::RECYC_W-1:0]    out_recyc_r, out_recyc_nxt;

  // Combinational helpers.
  logic [4:0]       slot_v;
  logic [SW-1:0]    slot_in;
  logic [SUM_W-1:0] mask;
  logic [SUM_W-1:0] op_a, op_b, sum, gran_full, cmp_val;
  logic             over;
  logic             need_new, exhausted, evt_last, out_free, load_out, in_fire;
  logic             in_ready;

  // Memory ports.
  logic           pend_we;
  logic [PAW-1:0] pend_waddr, pend_raddr;
  logic [PW-1:0]  pend_rdata;
  logic           fifo_we;
  logic [PW-1:0]  fifo_rdata;

  // Reduce the incoming frame slot into range by repeated subtraction.
  always_comb begin
    slot_v = 5'(in_ch.frame_slot);
    for (int k = 0; k < 3; k++) begin
      if (slot_v >= 5'(FRAME_SLOTS)) begin
        slot_v = slot_v - 5'(FRAME_SLOTS);
      end
    end
    slot_in = SW'(slot_v);
  end

  // Shared adder and comparator: rounds the size up in S_ALIGN and checks
  // the bumped offset against the page size in S_FIT.
  assign mask = (SUM_W'(1) << alog_r) - SUM_W'(1);

  always_comb begin
    case (state_r)
      ffpba_pkg::S_FIT: begin
        op_a = {1'b0, fill_off_r};
        op_b = {1'b0, gran_r};
      end
      default: begin
        op_a = {1'b0, req_r};
        op_b = mask;
      end
    endcase
  end

  assign sum       = op_a + op_b;
  assign gran_full = sum & ~mask;
  assign cmp_val   = (state_r == ffpba_pkg::S_FIT) ? sum : gran_full;
  assign over      = cmp_val > {1'b0, page_bytes_r};

  assign need_new  = !page_open_r || over;
  assign exhausted = (free_count_r == '0) && (pages_made_r >= CW'(MAX_PAGES));
  assign evt_last  = (CW'(idx_r) + CW'(1)) == evt_n_r;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_fire   = in_ch.valid && in_ready;

  // Pending lists live in one memory, one row of MAX_PAGES entries per frame.
  assign pend_waddr = PAW'(int'(slot_r) * MAX_PAGES + int'(pend_cnt_r[slot_r]));
  assign pend_raddr = PAW'(int'(slot_r) * MAX_PAGES + int'(idx_r));

  ffpba_ram #(
    .WIDTH (PW),
    .DEPTH (PDEPTH)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (open_page_r),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  // Recycled page FIFO; the head pointer always drives the read address.
  ffpba_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PAGES)
  ) u_free_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (free_tail_r),
    .wdata (pend_rdata),
    .raddr (free_head_r),
    .rdata (fifo_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffpba_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind == ffpba_pkg::KIND_FRAME) begin
            state_nxt = (pend_cnt_r[slot_in] == '0) ? ffpba_pkg::S_DONE
                                                    : ffpba_pkg::S_EVT_RD;
          end else begin
            state_nxt = ffpba_pkg::S_ALIGN;
          end
        end
      end
      ffpba_pkg::S_ALIGN: begin
        state_nxt = over ? ffpba_pkg::S_DONE : ffpba_pkg::S_FIT;
      end
      ffpba_pkg::S_FIT: begin
        if (need_new && !exhausted && (free_count_r != '0)) begin
          state_nxt = ffpba_pkg::S_POP;
        end else begin
          state_nxt = ffpba_pkg::S_DONE;
        end
      end
      ffpba_pkg::S_POP:    state_nxt = ffpba_pkg::S_DONE;
      ffpba_pkg::S_EVT_RD: state_nxt = ffpba_pkg::S_EVT_WR;
      ffpba_pkg::S_EVT_WR: begin
        state_nxt = evt_last ? ffpba_pkg::S_DONE : ffpba_pkg::S_EVT_RD;
      end
      ffpba_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = ffpba_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffpba_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath updates of each state.
  always_comb begin
    in_ready       = 1'b0;
    pend_we        = 1'b0;
    fifo_we        = 1'b0;
    load_out       = 1'b0;
    kind_nxt       = kind_r;
    req_nxt        = req_r;
    alog_nxt       = alog_r;
    slot_nxt       = slot_r;
    page_open_nxt  = page_open_r;
    open_page_nxt  = open_page_r;
    fill_off_nxt   = fill_off_r;
    pages_made_nxt = pages_made_r;
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    free_count_nxt = free_count_r;
    pend_cnt_nxt   = pend_cnt_r;
    gran_nxt       = gran_r;
    res_off_nxt    = res_off_r;
    status_nxt     = status_r;
    evt_n_nxt      = evt_n_r;
    idx_nxt        = idx_r;

    case (state_r)
      ffpba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          kind_nxt   = in_ch.kind;
          req_nxt    = in_ch.request_bytes;
          alog_nxt   = in_ch.alignment_log2;
          slot_nxt   = slot_in;
          idx_nxt    = '0;
          evt_n_nxt  = pend_cnt_r[slot_in];
          status_nxt = (in_ch.kind == ffpba_pkg::KIND_FRAME) ? ffpba_pkg::STAT_RECYCLED
                                                             : ffpba_pkg::STAT_OK;
        end
      end

      ffpba_pkg::S_ALIGN: begin
        gran_nxt = gran_full[ffpba_pkg::GRANT_W-1:0];
        if (over) begin
          status_nxt = ffpba_pkg::STAT_TOO_LARGE;
        end
      end

      ffpba_pkg::S_FIT: begin
        if (!need_new) begin
          // Fits in the open page: bump the offset.
          res_off_nxt  = fill_off_r;
          fill_off_nxt = sum[PB_W-1:0];
        end else if (exhausted) begin
          status_nxt = ffpba_pkg::STAT_NO_PAGE;
        end else begin
          // Retire the open page to this frame and take a new one.
          res_off_nxt   = '0;
          fill_off_nxt  = gran_r;
          page_open_nxt = 1'b1;
          if (page_open_r && (pend_cnt_r[slot_r] < CW'(MAX_PAGES))) begin
            pend_we              = 1'b1;
            pend_cnt_nxt[slot_r] = pend_cnt_r[slot_r] + CW'(1);
          end
          if (free_count_r != '0) begin
            free_head_nxt  = (free_head_r == PW'(MAX_PAGES - 1)) ? '0
                                                                 : free_head_r + PW'(1);
            free_count_nxt = free_count_r - CW'(1);
          end else begin
            open_page_nxt  = PW'(pages_made_r);
            pages_made_nxt = pages_made_r + CW'(1);
          end
        end
      end

      ffpba_pkg::S_POP: begin
        open_page_nxt = fifo_rdata;
      end

      ffpba_pkg::S_EVT_WR: begin
        // Move one pending page into the free FIFO.
        if (free_count_r < CW'(MAX_PAGES)) begin
          fifo_we        = 1'b1;
          free_tail_nxt  = (free_tail_r == PW'(MAX_PAGES - 1)) ? '0
                                                               : free_tail_r + PW'(1);
          free_count_nxt = free_count_r + CW'(1);
        end
        idx_nxt = idx_r + PW'(1);
        if (evt_last) begin
          pend_cnt_nxt[slot_r] = '0;
        end
      end

      ffpba_pkg::S_DONE: begin
        load_out = out_free;
      end

      default: begin
      end
    endcase
  end

  // Output register contents.
  always_comb begin
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_off_nxt    = out_off_r;
    out_gran_nxt   = out_gran_r;
    out_recyc_nxt  = out_recyc_r;
    if (load_out) begin
      out_status_nxt = status_r;
      out_page_nxt   = (status_r == ffpba_pkg::STAT_OK) ? ffpba_pkg::PAGE_ID_W'(open_page_r)
                                                        : '0;
      out_off_nxt    = (status_r == ffpba_pkg::STAT_OK) ? res_off_r[ffpba_pkg::OFFS_W-1:0]
                                                        : '0;
      out_gran_nxt   = (status_r == ffpba_pkg::STAT_OK) ? gran_r : '0;
      out_recyc_nxt  = (status_r == ffpba_pkg::STAT_RECYCLED) ? ffpba_pkg::RECYC_W'(evt_n_r)
                                                              : '0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffpba_pkg::S_IDLE;
      page_bytes_r <= ffpba_pkg::PAGE_BYTES_RST;
      page_open_r  <= 1'b0;
      open_page_r  <= '0;
      fill_off_r   <= '0;
      pages_made_r <= '0;
      free_head_r  <= '0;
      free_tail_r  <= '0;
      free_count_r <= '0;
      for (int s = 0; s < FRAME_SLOTS; s++) begin
        pend_cnt_r[s] <= '0;
      end
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        page_bytes_r <= cfg_wdata;
      end
      page_open_r  <= page_open_nxt;
      open_page_r  <= open_page_nxt;
      fill_off_r   <= fill_off_nxt;
      pages_made_r <= pages_made_nxt;
      free_head_r  <= free_head_nxt;
      free_tail_r  <= free_tail_nxt;
      free_count_r <= free_count_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    alog_r       <= alog_nxt;
    slot_r       <= slot_nxt;
    gran_r       <= gran_nxt;
    res_off_r    <= res_off_nxt;
    status_r     <= status_nxt;
    evt_n_r      <= evt_n_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_off_r    <= out_off_nxt;
    out_gran_r   <= out_gran_nxt;
    out_recyc_r  <= out_recyc_nxt;
  end

  // Ports.
  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.page_id        = out_page_r;
  assign out_ch.byte_offset    = out_off_r;
  assign out_ch.granted_bytes  = out_gran_r;
  assign out_ch.recycled_count = out_recyc_r;

  // The item kind is only needed to steer the first state; keep it visible
  // so an allocate is never mistaken for an event while in flight.
  logic kind_alloc_busy;
  assign kind_alloc_busy = (kind_r == ffpba_pkg::KIND_ALLOC) &&
                           (state_r == ffpba_pkg::S_EVT_RD);

endmodule

// File: hw/rtl/ffpba_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module ffpba_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ffpba_checker.sv
`timescale 1ns / 1ps
`include "frame_fenced_page_bump_allocator_assert.svh"

// Port-level checks on the allocator.
module ffpba_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ffpba_pkg::STAT_W-1:0]     out_status,
  input logic [ffpba_pkg::PAGE_ID_W-1:0]  out_page_id,
  input logic [ffpba_pkg::OFFS_W-1:0]     out_byte_offset,
  input logic [ffpba_pkg::GRANT_W-1:0]    out_granted_bytes,
  input logic [ffpba_pkg::RECYC_W-1:0]    out_recycled_count
);

  // One item at a time: the block is busy right after taking a transfer.
  `FFPBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // Failed allocations carry no page, offset, size or count.
  `FFPBA_ASSERT_NOW(a_fail_fields_zero, clk, rst_n, out_valid && (out_status == ffpba_pkg::STAT_TOO_LARGE || out_status == ffpba_pkg::STAT_NO_PAGE), out_page_id == '0 && out_byte_offset == '0 && out_granted_bytes == '0 && out_recycled_count == '0)

  // Frame results carry only the recycled count.
  `FFPBA_ASSERT_NOW(a_recycle_fields, clk, rst_n, out_valid && out_status == ffpba_pkg::STAT_RECYCLED, out_page_id == '0 && out_byte_offset == '0 && out_granted_bytes == '0)

  // Allocations never report recycled pages.
  `FFPBA_ASSERT_NOW(a_alloc_no_recycle, clk, rst_n, out_valid && out_status == ffpba_pkg::STAT_OK, out_recycled_count == '0)

  // A stalled result holds.
  `FFPBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_byte_offset))

endmodule

bind frame_fenced_page_bump_allocator ffpba_checker u_ffpba_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_page_id        (out_ch.page_id),
  .out_byte_offset    (out_ch.byte_offset),
  .out_granted_bytes  (out_ch.granted_bytes),
  .out_recycled_count (out_ch.recycled_count)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ffpba_pkg::*;

  localparam int MAX_PAGES   = 16;
  localparam int FRAME_SLOTS = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 145;

  // One item of the request channel, with the idle gap that follows its transfer.
  typedef struct {
    logic               kind;
    logic [REQ_W-1:0]   request_bytes;
    logic [ALOG_W-1:0]  alignment_log2;
    logic [SLOT_W-1:0]  frame_slot;
    int unsigned        gap;
  } alloc_req_t;

  typedef struct {
    logic [STAT_W-1:0]    status;
    logic [PAGE_ID_W-1:0] page_id;
    logic [OFFS_W-1:0]    byte_offset;
    logic [GRANT_W-1:0]   granted_bytes;
    logic [RECYC_W-1:0]   recycled_count;
  } alloc_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [PBYTES_W-1:0] cfg_wdata;

  ffpba_in_if  in_ch();
  ffpba_out_if out_ch();

  frame_fenced_page_bump_allocator #(
    .MAX_PAGES  (MAX_PAGES),
    .FRAME_SLOTS(FRAME_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Allocator state as the testbench tracks it.
  logic [PBYTES_W-1:0]  page_size;
  logic                 pg_open;
  logic [PAGE_ID_W-1:0] open_pg;
  logic [SUM_W-1:0]     fill_ofs;
  int unsigned          pages_built;
  logic [PAGE_ID_W-1:0] free_ring [MAX_PAGES];
  int unsigned          ring_head;
  int unsigned          ring_tail;
  int unsigned          ring_count;
  logic [PAGE_ID_W-1:0] frame_pages [FRAME_SLOTS][MAX_PAGES];
  int unsigned          frame_count [FRAME_SLOTS];

  alloc_req_t    request_queue[$];
  alloc_result_t pending_grants[$];
  alloc_req_t    cur_req;

  int          fail_count;
  int          cycle_count;
  int          items_sent;
  int          src_wait;
  int          sink_wait;
  int          hold_left;
  bit          hold_done;
  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned cur_frame;
  int unsigned allocs_in_frame;
  int unsigned frame_len;
  int          n_ok;
  int          n_large;
  int          n_no_page;
  int          n_frames;
  int          n_recycled;

  // Clock generation.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Computes the result of one item and advances the tracked allocator state.
  function automatic alloc_result_t allocate_or_recycle(input alloc_req_t it);
    alloc_result_t        r;
    logic [SUM_W-1:0]     mask;
    logic [SUM_W-1:0]     granted;
    logic [PAGE_ID_W-1:0] next_pg;
    int unsigned          slot;
    int unsigned          n;
    int unsigned          i;
    r = '{default: '0};
    slot = it.frame_slot % FRAME_SLOTS;
    if (it.kind == KIND_FRAME) begin
      // A completed frame hands its retired pages back in retirement order.
      n = frame_count[slot];
      if (n > MAX_PAGES) n = MAX_PAGES;
      for (i = 0; i < n; i++) begin
        if (ring_count < MAX_PAGES) begin
          free_ring[ring_tail] = frame_pages[slot][i];
          ring_tail = (ring_tail + 1) % MAX_PAGES;
          ring_count++;
        end
      end
      frame_count[slot] = 0;
      r.status = STAT_RECYCLED;
      r.recycled_count = RECYC_W'(n);
      return r;
    end
    mask = (SUM_W'(1) << it.alignment_log2) - SUM_W'(1);
    granted = (SUM_W'(it.request_bytes) + mask) & ~mask;
    if (granted > SUM_W'(page_size)) begin
      r.status = STAT_TOO_LARGE;
      return r;
    end
    if (!pg_open || fill_ofs + granted > SUM_W'(page_size)) begin
      // The pool is exhausted only when nothing is recycled and every page exists.
      if (ring_count == 0 && pages_built >= MAX_PAGES) begin
        r.status = STAT_NO_PAGE;
        return r;
      end
      if (pg_open && frame_count[slot] < MAX_PAGES) begin
        frame_pages[slot][frame_count[slot]] = open_pg;
        frame_count[slot]++;
      end
      if (ring_count > 0) begin
        next_pg = free_ring[ring_head];
        ring_head = (ring_head + 1) % MAX_PAGES;
        ring_count--;
      end else begin
        next_pg = PAGE_ID_W'(pages_built);
        pages_built++;
      end
      pg_open = 1'b1;
      open_pg = next_pg;
      fill_ofs = '0;
    end
    r.status = STAT_OK;
    r.page_id = open_pg;
    r.byte_offset = fill_ofs[OFFS_W-1:0];
    r.granted_bytes = granted[GRANT_W-1:0];
    fill_ofs = fill_ofs + granted;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(input bit enable);
    int unsigned r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic alloc_req_t mk_alloc(input int unsigned bytes, input int unsigned alog,
                                          input int unsigned slot);
    alloc_req_t it;
    it.kind = KIND_ALLOC;
    it.request_bytes = REQ_W'(bytes);
    it.alignment_log2 = ALOG_W'(alog);
    it.frame_slot = SLOT_W'(slot);
    it.gap = pick_gap(src_idle_en);
    return it;
  endfunction

  function automatic alloc_req_t mk_event(input int unsigned slot);
    alloc_req_t it;
    it = mk_alloc($urandom_range(0, 16777216), $urandom_range(0, 12), slot);
    it.kind = KIND_FRAME;
    return it;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Random items: mostly allocations in the current frame with frames closed in turn,
  // plus stray events and allocations tagged with other frames.
  task automatic queue_random(input int unsigned count);
    int unsigned r;
    int unsigned s;
    int unsigned bytes;
    int unsigned alog;
    int unsigned slot;
    int unsigned pb;
    repeat (count) begin
      pb = page_size;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        request_queue.push_back(mk_event($urandom_range(0, 3)));
      end else if (allocs_in_frame >= frame_len) begin
        // Move on to the next frame and complete the one two frames back.
        cur_frame = (cur_frame + 1) % FRAME_SLOTS;
        request_queue.push_back(mk_event((cur_frame + 2) % FRAME_SLOTS));
        allocs_in_frame = 0;
        frame_len = $urandom_range(3, 14);
      end else begin
        slot = (r < 14) ? $urandom_range(0, 3) : cur_frame;
        s = $urandom_range(0, 99);
        if (s < 8) bytes = 0;
        else if (s < 60) bytes = $urandom_range(0, pb / 8);
        else if (s < 85) bytes = $urandom_range(0, pb);
        else if (s < 93) bytes = pb - $urandom_range(0, 16);
        else bytes = $urandom_range(0, 16777216);
        alog = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 12);
        request_queue.push_back(mk_alloc(bytes, alog, slot));
        allocs_in_frame++;
      end
    end
  endtask

  // Waits until every item is sent and every result is back, then waits out the tail.
  task automatic drain(input int unsigned tail);
    do @(negedge clk);
    while (request_queue.size() != 0 || in_ch.valid || pending_grants.size() != 0);
    repeat (tail) @(negedge clk);
  endtask

  task automatic set_page_size(input int unsigned bytes);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= PBYTES_W'(bytes);
    page_size = PBYTES_W'(bytes);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Request driver: presents queued items and predicts each one at its transfer.
  always @(posedge clk) begin : drive_proc
    alloc_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_grants.push_back(allocate_or_recycle(cur_req));
        items_sent <= items_sent + 1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered item until it is taken.
      end else if (src_wait > 0) begin
        src_wait <= src_wait - 1;
        in_ch.valid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        nxt = request_queue.pop_front();
        cur_req <= nxt;
        in_ch.valid <= 1'b1;
        in_ch.kind <= nxt.kind;
        in_ch.request_bytes <= nxt.request_bytes;
        in_ch.alignment_log2 <= nxt.alignment_log2;
        in_ch.frame_slot <= nxt.frame_slot;
        src_wait <= nxt.gap;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each transfer with the oldest prediction.
  always @(posedge clk) begin : check_proc
    alloc_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_grants.size() == 0) begin
          $error("result with no prediction waiting: status %0d", out_ch.status);
          fail_count++;
        end else begin
          want = pending_grants.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("page_id", want.page_id, out_ch.page_id);
          check_field("byte_offset", want.byte_offset, out_ch.byte_offset);
          check_field("granted_bytes", want.granted_bytes, out_ch.granted_bytes);
          check_field("recycled_count", want.recycled_count, out_ch.recycled_count);
          case (want.status)
            STAT_OK:        n_ok++;
            STAT_TOO_LARGE: n_large++;
            STAT_NO_PAGE:   n_no_page++;
            default: begin
              n_frames++;
              n_recycled += want.recycled_count;
            end
          endcase
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_idle_en && $urandom_range(0, 3) == 0) sink_wait <= pick_gap(1'b1);
      end
    end
  end

  // One long receiver hold-off partway through, so the block backs up to its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= 200) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stim_proc
    int unsigned sizes [6];
    int unsigned p;
    sizes = '{16777216, 256, 0, 65536, 4096, 256};
    sizes[2] = $urandom_range(300, 200000);
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.alignment_log2 = '0;
    in_ch.frame_slot = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    items_sent = 0;
    n_ok = 0;
    n_large = 0;
    n_no_page = 0;
    n_frames = 0;
    n_recycled = 0;
    cur_frame = 0;
    allocs_in_frame = 0;
    frame_len = 8;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    page_size = PAGE_BYTES_RST;
    pg_open = 1'b0;
    open_pg = '0;
    fill_ofs = '0;
    pages_built = 0;
    ring_head = 0;
    ring_tail = 0;
    ring_count = 0;
    foreach (frame_count[i]) frame_count[i] = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items at the reset page size.
    request_queue.push_back(mk_alloc(0, 0, 0));          // zero size opens a page
    request_queue.push_back(mk_alloc(1, 0, 0));
    request_queue.push_back(mk_alloc(1, 12, 0));         // widest alignment the bench uses
    request_queue.push_back(mk_alloc(65536, 0, 0));      // full page, forces a new one
    request_queue.push_back(mk_alloc(0, 12, 0));         // zero size at the end of a full page
    request_queue.push_back(mk_alloc(65537, 0, 1));      // just too large
    request_queue.push_back(mk_alloc(16777216, 12, 3));  // largest request the bench uses
    request_queue.push_back(mk_alloc(65535, 12, 2));     // rounds up to a page
    request_queue.push_back(mk_event(0));
    request_queue.push_back(mk_event(1));                // empty list
    request_queue.push_back(mk_alloc(100, 3, 1));        // reuses a recycled page
    // Run the pool dry without completing any frame.
    repeat (15) request_queue.push_back(mk_alloc(65536, 0, 1));
    request_queue.push_back(mk_event(1));
    request_queue.push_back(mk_event(2));
    drain(8);

    // Random phases over several page sizes, extremes included.
    for (p = 0; p < 6; p++) begin
      src_idle_en = (p != 3);
      sink_idle_en = (p != 3);
      set_page_size(sizes[p]);
      if (p == 0) begin
        // Largest page: an offset equal to the page size reads back as 0.
        request_queue.push_back(mk_alloc(16777216, 0, cur_frame));
        request_queue.push_back(mk_alloc(0, 0, cur_frame));
      end
      queue_random(PHASE_ITEMS);
      drain(8);
    end

    drain(40);
    if (pending_grants.size() != 0) begin
      $error("%0d predicted results never arrived", pending_grants.size());
      fail_count++;
    end
    $display("Covered %0d items: %0d granted, %0d oversize, %0d pool exhausted.",
             items_sent, n_ok, n_large, n_no_page);
    $display("Frame completions: %0d, returning %0d pages; six page sizes after reset.",
             n_frames, n_recycled);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
